@@ sv/sqlx_pkg.sv @@
// sqlx_pkg: shared types and codes for the SQL lexer.
// Depends on nothing.
`default_nettype none
package sqlx_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_statement;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [4:0]         token_kind;
        logic [3:0]         error_code;
        logic [19:0]        token_offset;
        logic [20:0]        token_length;
        logic signed [63:0] integer_value;
        logic [6:0]         string_char;
        logic               done_ok;
        logic               last_of_run;
    } out_item_t;

    localparam logic [1:0] RK_TOKEN = 2'd0;
    localparam logic [1:0] RK_CHAR  = 2'd1;
    localparam logic [1:0] RK_DONE  = 2'd2;

    localparam logic [4:0] TK_ERROR = 5'd0;
    localparam logic [4:0] TK_WORD  = 5'd1;
    localparam logic [4:0] TK_INT   = 5'd2;
    localparam logic [4:0] TK_FLOAT = 5'd3;
    localparam logic [4:0] TK_STR   = 5'd4;
    localparam logic [4:0] TK_LT    = 5'd14;
    localparam logic [4:0] TK_GT    = 5'd15;
    localparam logic [4:0] TK_LE    = 5'd16;
    localparam logic [4:0] TK_GE    = 5'd17;
    localparam logic [4:0] TK_NE    = 5'd18;

    localparam logic [3:0] EC_CHAR     = 4'd1;
    localparam logic [3:0] EC_LETTER   = 4'd2;
    localparam logic [3:0] EC_HEX      = 4'd3;
    localparam logic [3:0] EC_FLOAT    = 4'd4;
    localparam logic [3:0] EC_OCT      = 4'd5;
    localparam logic [3:0] EC_INT      = 4'd6;
    localparam logic [3:0] EC_OVF      = 4'd7;
    localparam logic [3:0] EC_BSEND    = 4'd8;
    localparam logic [3:0] EC_ESC      = 4'd9;
    localparam logic [3:0] EC_QCHAR    = 4'd10;
    localparam logic [3:0] EC_UNTERM   = 4'd11;
    localparam logic [3:0] EC_TOOLONG  = 4'd12;

    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;

    // Lexer modes, one-hot.
    typedef enum logic [8:0] {
        M_IDLE = 9'b000000001,
        M_WORD = 9'b000000010,
        M_DEC  = 9'b000000100,
        M_OCT  = 9'b000001000,
        M_HEX  = 9'b000010000,
        M_STR  = 9'b000100000,
        M_ESC  = 9'b001000000,
        M_LT   = 9'b010000000,
        M_GT   = 9'b100000000
    } mode_t;

    // Up to three results of one byte, handed from the front to the back.
    typedef struct packed {
        logic [1:0]      count;
        out_item_t [2:0] item;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            8'h28: k = 5'd5;
            8'h29: k = 5'd6;
            8'h5B: k = 5'd7;
            8'h5D: k = 5'd8;
            8'h2C: k = 5'd9;
            8'h3B: k = 5'd10;
            8'h2A: k = 5'd11;
            8'h2E: k = 5'd12;
            8'h3D: k = 5'd13;
            8'h2B: k = 5'd19;
            8'h2D: k = 5'd20;
            8'h7E: k = 5'd21;
            8'h26: k = 5'd22;
            8'h7C: k = 5'd23;
            8'h5E: k = 5'd24;
            8'h2F: k = 5'd25;
            8'h25: k = 5'd26;
            default: k = TK_ERROR;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ sv/sqlx_front.sv @@
// sqlx_front: per-byte lexer state machine; turns one byte into a bundle of up to three results.
// Depends on sqlx_pkg.
`default_nettype none
module sqlx_front #(
    parameter int MAX_BYTES = 1048576
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  sqlx_pkg::in_item_t   in_item,
    output sqlx_pkg::bundle_t    bundle
);
    import sqlx_pkg::*;

    localparam int PW = $clog2(MAX_BYTES + 1) + 1;

    mode_t       mode_reg, mode_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] start_reg, start_next;
    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [1:0]  fst_reg, fst_next;
    logic        fbad_reg, fbad_next;
    logic        dq_reg, dq_next;
    logic        err_reg, err_next;

    always_comb
    begin
        logic [7:0]   b;
        logic         eos;
        logic         again;
        logic         fin_num;
        logic         fin_hex;
        logic [PW-1:0] len;
        logic [PW-1:0] pos1;
        logic [3:0]   d;
        logic [6:0]   ec;
        logic         esc_ok;
        logic [4:0]   pk;
        logic [63:0]  acc10;
        out_item_t    r;

        b = in_item.text_byte;
        eos = in_item.end_of_statement;
        mode_next = mode_reg;
        pos_next = pos_reg;
        start_next = start_reg;
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        fst_next = fst_reg;
        fbad_next = fbad_reg;
        dq_next = dq_reg;
        err_next = err_reg;
        bundle = '0;
        again = 1'b0;
        fin_num = 1'b0;
        fin_hex = 1'b0;
        len = pos_reg - start_reg;
        pos1 = pos_reg + PW'(1);
        d = b[3:0];
        ec = 7'd0;
        esc_ok = 1'b1;
        pk = punct_kind(b);
        acc10 = (acc_reg << 3) + (acc_reg << 1) + 64'(d);
        r = '0;

        if (in_valid) begin
            if (!err_reg) begin
                if (pos_reg >= PW'(MAX_BYTES)) begin
                    r = '0;
                    r.error_code = EC_TOOLONG;
                    r.token_length = 21'(MAX_BYTES);
                    bundle.item[bundle.count] = r;
                    bundle.count = bundle.count + 2'd1;
                    err_next = 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    case (mode_reg)
                        M_WORD:
                        begin
                            if (!(is_alpha(b) || is_digit(b) || b == 8'h5F)) begin
                                r = '0;
                                r.token_kind = TK_WORD;
                                r.token_offset = 20'(start_reg);
                                r.token_length = 21'(len);
                                bundle.item[bundle.count] = r;
                                bundle.count = bundle.count + 2'd1;
                                mode_next = M_IDLE;
                                again = 1'b1;
                            end
                        end
                        M_DEC, M_OCT:
                        begin
                            if (is_digit(b)) begin
                                if (fst_reg == 2'd2) fst_next = 2'd3;
                                if (mode_reg == M_OCT) begin
                                    if (d > 4'd7) ovf_next = 1'b1;
                                    else begin
                                        if (acc_reg[63:61] != 3'd0) ovf_next = 1'b1;
                                        acc_next = {acc_reg[60:0], d[2:0]};
                                    end
                                end else begin
                                    if (acc_reg > DEC_LIMIT ||
                                        (acc_reg == DEC_LIMIT && d > 4'd5))
                                        ovf_next = 1'b1;
                                    acc_next = acc10;
                                end
                            end else if (mode_reg == M_OCT && pos_reg == start_reg + PW'(1)
                                         && b == 8'h78 && !eos) begin
                                mode_next = M_HEX;
                                acc_next = '0;
                                ovf_next = 1'b0;
                            end else if (b == 8'h2E) begin
                                if (fst_reg == 2'd0) fst_next = 2'd1;
                                else fbad_next = 1'b1;
                            end else if (b == 8'h65 || b == 8'h45) begin
                                if (fst_reg < 2'd2) fst_next = 2'd2;
                                else fbad_next = 1'b1;
                            end else if (is_alpha(b)) begin
                                r = '0;
                                r.error_code = EC_LETTER;
                                r.token_offset = 20'(pos_reg);
                                r.token_length = 21'd1;
                                bundle.item[bundle.count] = r;
                                bundle.count = bundle.count + 2'd1;
                                err_next = 1'b1;
                                mode_next = M_IDLE;
                            end else begin
                                fin_num = 1'b1;
                                again = 1'b1;
                            end
                        end
                        M_HEX:
                        begin
                            if (is_digit(b) || (b >= 8'h61 && b <= 8'h66) ||
                                (b >= 8'h41 && b <= 8'h46)) begin
                                if (acc_reg[63:60] != 4'd0) ovf_next = 1'b1;
                                acc_next = {acc_reg[59:0],
                                            is_digit(b) ? d : 4'(d + 4'd9)};
                            end else if (is_alpha(b)) begin
                                r = '0;
                                r.error_code = EC_LETTER;
                                r.token_offset = 20'(start_reg);
                                r.token_length = 21'(len);
                                bundle.item[bundle.count] = r;
                                bundle.count = bundle.count + 2'd1;
                                err_next = 1'b1;
                                mode_next = M_IDLE;
                            end else begin
                                fin_hex = 1'b1;
                                again = 1'b1;
                            end
                        end
                        M_STR:
                        begin
                            r = '0;
                            if (b == (dq_reg ? 8'h22 : 8'h27)) begin
                                r.token_kind = TK_STR;
                                r.token_offset = 20'(start_reg);
                                r.token_length = 21'(pos1 - start_reg);
                                mode_next = M_IDLE;
                            end else if (b == 8'h5C) begin
                                mode_next = M_ESC;
                            end else if (b >= 8'd32 && b < 8'd127) begin
                                r.result_kind = RK_CHAR;
                                r.string_char = b[6:0];
                            end else begin
                                r.error_code = EC_QCHAR;
                                r.token_offset = 20'(pos_reg);
                                r.token_length = 21'd1;
                                err_next = 1'b1;
                                mode_next = M_IDLE;
                            end
                            if (b != 8'h5C || b == (dq_reg ? 8'h22 : 8'h27)) begin
                                bundle.item[bundle.count] = r;
                                bundle.count = bundle.count + 2'd1;
                            end
                        end
                        M_ESC:
                        begin
                            case (b)
                                8'h30: ec = 7'd0;
                                8'h62: ec = 7'd8;
                                8'h6E: ec = 7'd10;
                                8'h72: ec = 7'd13;
                                8'h74: ec = 7'd9;
                                8'h22: ec = 7'h22;
                                8'h27: ec = 7'h27;
                                default: esc_ok = 1'b0;
                            endcase
                            r = '0;
                            if (esc_ok) begin
                                r.result_kind = RK_CHAR;
                                r.string_char = ec;
                                mode_next = M_STR;
                            end else begin
                                r.error_code = EC_ESC;
                                r.token_offset = 20'(start_reg);
                                r.token_length = 21'(pos1 - start_reg);
                                err_next = 1'b1;
                                mode_next = M_IDLE;
                            end
                            bundle.item[bundle.count] = r;
                            bundle.count = bundle.count + 2'd1;
                        end
                        M_LT, M_GT:
                        begin
                            r = '0;
                            r.token_offset = 20'(start_reg);
                            mode_next = M_IDLE;
                            if (b == 8'h3D) begin
                                r.token_kind = (mode_reg == M_LT) ? TK_LE : TK_GE;
                                r.token_length = 21'd2;
                            end else if (b == 8'h3E && mode_reg == M_LT) begin
                                r.token_kind = TK_NE;
                                r.token_length = 21'd2;
                            end else begin
                                r.token_kind = (mode_reg == M_LT) ? TK_LT : TK_GT;
                                r.token_length = 21'd1;
                                again = 1'b1;
                            end
                            bundle.item[bundle.count] = r;
                            bundle.count = bundle.count + 2'd1;
                        end
                        default:
                        begin
                            mode_next = M_IDLE;
                            again = 1'b1;
                        end
                    endcase

                    // Number completion (on a separator byte or at end of statement).
                    if (fin_num || fin_hex ||
                        (eos && !err_next && again == 1'b0 &&
                         (mode_next == M_DEC || mode_next == M_OCT || mode_next == M_HEX)))
                    begin
                        logic [PW-1:0] nl;
                        logic          nhex;
                        nl = (fin_num || fin_hex) ? len : (pos1 - start_reg);
                        nhex = fin_hex || (!fin_num && mode_next == M_HEX);
                        r = '0;
                        r.token_offset = 20'(start_reg);
                        r.token_length = 21'(nl);
                        if (nhex) begin
                            if (nl <= PW'(2) || ovf_next) r.error_code = EC_HEX;
                            else begin
                                r.token_kind = TK_INT;
                                r.integer_value = acc_next;
                            end
                        end else if (fst_next != 2'd0) begin
                            if (fbad_next || fst_next == 2'd2) r.error_code = EC_FLOAT;
                            else r.token_kind = TK_FLOAT;
                        end else if (mode_next == M_OCT) begin
                            if (ovf_next) r.error_code = EC_OCT;
                            else begin
                                r.token_kind = TK_INT;
                                r.integer_value = acc_next;
                            end
                        end else if (ovf_next) r.error_code = EC_INT;
                        else if (acc_next > INT64_MAX) r.error_code = EC_OVF;
                        else begin
                            r.token_kind = TK_INT;
                            r.integer_value = acc_next;
                        end
                        if (r.token_kind == TK_ERROR) err_next = 1'b1;
                        mode_next = M_IDLE;
                        bundle.item[bundle.count] = r;
                        bundle.count = bundle.count + 2'd1;
                    end

                    // Fresh lexing of this byte from idle.
                    if (again && !err_next) begin
                        if (!(b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D)) begin
                            start_next = pos_reg;
                            if (is_alpha(b)) mode_next = M_WORD;
                            else if (is_digit(b)) begin
                                mode_next = (b == 8'h30) ? M_OCT : M_DEC;
                                acc_next = 64'(d);
                                ovf_next = 1'b0;
                                fst_next = 2'd0;
                                fbad_next = 1'b0;
                            end else if (b == 8'h27 || b == 8'h22) begin
                                mode_next = M_STR;
                                dq_next = (b == 8'h22);
                            end else if (b == 8'h3C) mode_next = M_LT;
                            else if (b == 8'h3E) mode_next = M_GT;
                            else begin
                                r = '0;
                                r.token_offset = 20'(pos_reg);
                                r.token_length = 21'd1;
                                if (pk != TK_ERROR) r.token_kind = pk;
                                else begin
                                    r.error_code = EC_CHAR;
                                    err_next = 1'b1;
                                end
                                bundle.item[bundle.count] = r;
                                bundle.count = bundle.count + 2'd1;
                            end
                        end
                    end

                    // Flush of the open token at end of statement (also a number opened by this byte).
                    if (eos && !err_next) begin
                        logic [PW-1:0] fl;
                        fl = pos1 - start_next;
                        r = '0;
                        r.token_offset = 20'(start_next);
                        r.token_length = 21'(fl);
                        case (mode_next)
                            M_WORD: r.token_kind = TK_WORD;
                            M_STR: r.error_code = EC_UNTERM;
                            M_ESC: r.error_code = EC_BSEND;
                            M_LT:
                            begin
                                r.token_kind = TK_LT;
                                r.token_length = 21'd1;
                            end
                            M_GT:
                            begin
                                r.token_kind = TK_GT;
                                r.token_length = 21'd1;
                            end
                            M_DEC, M_OCT, M_HEX:
                            begin
                                r.token_length = 21'(fl);
                                if (mode_next == M_HEX) begin
                                    if (fl <= PW'(2) || ovf_next) r.error_code = EC_HEX;
                                    else begin
                                        r.token_kind = TK_INT;
                                        r.integer_value = acc_next;
                                    end
                                end else if (fst_next != 2'd0) begin
                                    if (fbad_next || fst_next == 2'd2)
                                        r.error_code = EC_FLOAT;
                                    else r.token_kind = TK_FLOAT;
                                end else if (mode_next == M_OCT) begin
                                    if (ovf_next) r.error_code = EC_OCT;
                                    else begin
                                        r.token_kind = TK_INT;
                                        r.integer_value = acc_next;
                                    end
                                end else if (ovf_next) r.error_code = EC_INT;
                                else if (acc_next > INT64_MAX) r.error_code = EC_OVF;
                                else begin
                                    r.token_kind = TK_INT;
                                    r.integer_value = acc_next;
                                end
                            end
                            default: r = '0;
                        endcase
                        if (mode_next != M_IDLE) begin
                            if (r.token_kind == TK_ERROR) err_next = 1'b1;
                            bundle.item[bundle.count] = r;
                            bundle.count = bundle.count + 2'd1;
                        end
                        mode_next = M_IDLE;
                    end
                end
            end

            if (eos) begin
                r = '0;
                r.result_kind = RK_DONE;
                r.done_ok = !err_next;
                bundle.item[bundle.count] = r;
                bundle.count = bundle.count + 2'd1;
                mode_next = M_IDLE;
                pos_next = '0;
                start_next = '0;
                acc_next = '0;
                ovf_next = 1'b0;
                fst_next = 2'd0;
                fbad_next = 1'b0;
                dq_next = 1'b0;
                err_next = 1'b0;
            end else if (!err_next) begin
                pos_next = pos1;
            end
            if (bundle.count != 2'd0)
                bundle.item[bundle.count - 2'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            pos_reg <= '0;
            start_reg <= '0;
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            fst_reg <= 2'd0;
            fbad_reg <= 1'b0;
            dq_reg <= 1'b0;
            err_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            start_reg <= start_next;
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
            fst_reg <= fst_next;
            fbad_reg <= fbad_next;
            dq_reg <= dq_next;
            err_reg <= err_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/sqlx_back.sv @@
// sqlx_back: result queue; takes bundles of up to three results, pops one at a time.
// Depends on sqlx_pkg.
`default_nettype none
module sqlx_back #(
    parameter int DEPTH = 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  sqlx_pkg::bundle_t    bundle,
    output logic                 has_room,
    output logic                 empty,
    input  wire                  pop,
    output sqlx_pkg::out_item_t  head
);
    import sqlx_pkg::*;

    localparam int AW = $clog2(DEPTH);

    out_item_t        mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_pop;
    logic [1:0]       nwr;

    assign nwr = wr_en ? bundle.count : 2'd0;
    assign do_pop = pop && !empty;
    assign empty = (cnt_reg == '0);
    assign has_room = (cnt_reg <= (AW+1)'(DEPTH - 3));
    assign head = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + (AW+1)'(nwr) - (AW+1)'(do_pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nwr) mem_reg[wp_reg + AW'(i)] <= bundle.item[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg <= wp_reg + AW'(nwr);
            rp_reg <= rp_reg + AW'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/sql_lexer.sv @@
// sql_lexer: SQL tokenizer top level, one statement byte per request.
// The front is combinational; the results of a taken byte are written straight into the result queue.
// Throughput: one byte per cycle while the 8-entry result queue has room for three;
// popping one result per cycle drains it, so bytes giving several results slow the input.
// Reset: rst_n asynchronous, active low; clears lexer state and empties the queue.
// Depends on sqlx_pkg, sqlx_front, sqlx_back.
`default_nettype none
module sql_lexer #(
    parameter int MAX_STATEMENT_BYTES = 1048576
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  sqlx_pkg::in_item_t   in_item,
    output logic                 empty,
    input  wire                  pop,
    output sqlx_pkg::out_item_t  out_item
);
    import sqlx_pkg::*;

    bundle_t bundle;
    logic    has_room;
    logic    take;

    // Front accepts a request only when the queue can absorb a worst-case byte.
    assign full = !has_room;
    assign take = push && has_room;

    sqlx_front #(.MAX_BYTES(MAX_STATEMENT_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(take), .in_item(in_item), .bundle(bundle)
    );

    sqlx_back #(.DEPTH(8)) u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(take), .bundle(bundle),
        .has_room(has_room), .empty(empty), .pop(pop), .head(out_item)
    );

    // A byte always leaves the queue non-empty when it marks the end.
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && in_item.end_of_statement) |=> !empty)
        else $error("end byte gave no result");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.result_kind == RK_DONE) |-> out_item.last_of_run)
        else $error("done result not last of run");

endmodule
`default_nettype wire
